// ===== src/pid_pkg.sv =====
package pid_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int IO_W       = 32;
    localparam int PERIOD_W   = 31;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DER_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd6;

    localparam int STEP_W  = 5;
    localparam int N_STEPS = 22;

    localparam logic [STEP_W-1:0] STEP_INC_ENTRY = 5'd8;
    localparam logic [STEP_W-1:0] STEP_TAIL      = 5'd12;
    localparam logic [STEP_W-1:0] STEP_OUT       = 5'd21;

    typedef struct packed {
        logic signed [IO_W-1:0] setpoint;
        logic signed [IO_W-1:0] feedback;
        logic [PERIOD_W-1:0]    period;
    } t_in_item;

    typedef struct packed {
        logic signed [IO_W-1:0] drive;
        logic                   drive_clamped;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SUB,
        OP_ADD,
        OP_MOV,
        OP_CLI,
        OP_CLD,
        OP_ACCLD,
        OP_ACCADD,
        OP_SATACC,
        OP_MUL,
        OP_DIV,
        OP_CLO
    } t_op;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_SP,
        SRC_FB,
        SRC_PER,
        SRC_ERR,
        SRC_LERR,
        SRC_LDER,
        SRC_INTEG,
        SRC_PROP,
        SRC_DER,
        SRC_TMP,
        SRC_SUM,
        SRC_GP,
        SRC_GI,
        SRC_GD
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_ERR,
        DST_LERR,
        DST_LDER,
        DST_INTEG,
        DST_PROP,
        DST_DER,
        DST_TMP,
        DST_SUM
    } t_dst;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_INC,
        COND_POS
    } t_cond;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } t_state;

    typedef struct packed {
        t_op               op;
        t_src              src_a;
        t_src              src_b;
        t_dst              dst;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic   load;
        logic   fire;
        t_uword uw;
    } t_dp_ctl;

    typedef struct packed {
        logic unit_done;
        logic out_free;
    } t_dp_stat;

    function automatic t_uword f_uw(input t_op op, input t_src a, input t_src b,
                                    input t_dst d, input t_cond c,
                                    input logic [STEP_W-1:0] t);
        t_uword w;
        w.op     = op;
        w.src_a  = a;
        w.src_b  = b;
        w.dst    = d;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] s);
        t_uword w;
        case (s)
            // common head
            5'd0:  w = f_uw(OP_SUB, SRC_SP, SRC_FB, DST_ERR, COND_NONE, '0);
            5'd1:  w = f_uw(OP_SUB, SRC_ERR, SRC_LERR, DST_DER, COND_NONE, '0);
            5'd2:  w = f_uw(OP_DIV, SRC_DER, SRC_PER, DST_DER, COND_NONE, '0);
            5'd3:  w = f_uw(OP_MOV, SRC_ERR, SRC_ZERO, DST_LERR, COND_INC, STEP_INC_ENTRY);
            // position form
            5'd4:  w = f_uw(OP_MUL, SRC_ERR, SRC_PER, DST_TMP, COND_NONE, '0);
            5'd5:  w = f_uw(OP_ADD, SRC_INTEG, SRC_TMP, DST_TMP, COND_NONE, '0);
            5'd6:  w = f_uw(OP_CLI, SRC_TMP, SRC_ZERO, DST_INTEG, COND_NONE, '0);
            5'd7:  w = f_uw(OP_MOV, SRC_ERR, SRC_ZERO, DST_PROP, COND_ALWAYS, STEP_TAIL);
            // incremental form
            5'd8:  w = f_uw(OP_CLI, SRC_ERR, SRC_ZERO, DST_INTEG, COND_NONE, '0);
            5'd9:  w = f_uw(OP_MOV, SRC_DER, SRC_ZERO, DST_PROP, COND_NONE, '0);
            5'd10: w = f_uw(OP_SUB, SRC_PROP, SRC_LDER, DST_DER, COND_NONE, '0);
            5'd11: w = f_uw(OP_MOV, SRC_DER, SRC_ZERO, DST_LDER, COND_NONE, '0);
            // common tail; step 20 runs only in incremental form
            5'd12: w = f_uw(OP_CLD, SRC_DER, SRC_ZERO, DST_DER, COND_NONE, '0);
            5'd13: w = f_uw(OP_MUL, SRC_GP, SRC_PROP, DST_TMP, COND_NONE, '0);
            5'd14: w = f_uw(OP_ACCLD, SRC_TMP, SRC_ZERO, DST_NONE, COND_NONE, '0);
            5'd15: w = f_uw(OP_MUL, SRC_GI, SRC_INTEG, DST_TMP, COND_NONE, '0);
            5'd16: w = f_uw(OP_ACCADD, SRC_TMP, SRC_ZERO, DST_NONE, COND_NONE, '0);
            5'd17: w = f_uw(OP_MUL, SRC_GD, SRC_DER, DST_TMP, COND_NONE, '0);
            5'd18: w = f_uw(OP_ACCADD, SRC_TMP, SRC_ZERO, DST_NONE, COND_NONE, '0);
            5'd19: w = f_uw(OP_SATACC, SRC_ZERO, SRC_ZERO, DST_SUM, COND_POS, STEP_OUT);
            5'd20: w = f_uw(OP_MUL, SRC_SUM, SRC_PER, DST_SUM, COND_NONE, '0);
            5'd21: w = f_uw(OP_CLO, SRC_SUM, SRC_ZERO, DST_NONE, COND_NONE, '0);
            default: w = f_uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, COND_ALWAYS, '0);
        endcase
        return w;
    endfunction

endpackage

// ===== src/pid_mul.sv =====
module pid_mul import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic signed [((DATA_WIDTH > 32) ? DATA_WIDTH : 32):0] i_a,
    input  logic signed [((DATA_WIDTH > 32) ? DATA_WIDTH : 32):0] i_b,
    output logic                                          o_done,
    output logic signed [DATA_WIDTH-1:0]                  o_p
);

    localparam int W     = DATA_WIDTH;
    localparam int MW    = (W > 32) ? W : 32;
    localparam int NCH   = (MW + 15) / 16;
    localparam int BPW   = NCH * 16;
    localparam int PW    = MW + BPW;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [MW-1:0]    r_ma;
    logic [BPW-1:0]   r_mb;
    logic [PW-1:0]    r_acc;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [MW-1:0]    mag_a;
    logic [MW-1:0]    mag_b;
    logic [MW+15:0]   pp;
    logic [PW-1:0]    shifted;
    logic [PW-1:0]    cap;
    logic [PW-1:0]    m;

    assign mag_a = i_a[MW] ? MW'(-i_a) : MW'(i_a);
    assign mag_b = i_b[MW] ? MW'(-i_b) : MW'(i_b);
    assign pp    = r_ma * r_mb[BPW-1 -: 16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NCH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one 16-bit slice of the multiplier per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag_a;
            r_mb  <= BPW'(mag_b);
            r_neg <= i_a[MW] ^ i_b[MW];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << 16) + PW'(pp);
            r_mb  <= r_mb << 16;
        end
    end

    always_comb begin
        shifted = r_acc >> FRAC_BITS;
        cap     = r_neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
        m       = (shifted > cap) ? cap : shifted;
        o_p     = r_neg ? -m[W-1:0] : m[W-1:0];
    end

    assign o_done = r_done;

endmodule

// ===== src/pid_div.sv =====
module pid_div import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic [PERIOD_W-1:0]          i_den,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_q
);

    localparam int W     = DATA_WIDTH;
    localparam int NW    = W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]       r_qd;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_den;
    logic                r_neg;
    logic                r_zero;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [W-1:0]        mag;
    logic [PERIOD_W:0]   sh;
    logic [PERIOD_W:0]   diff;
    logic                ge;
    logic [NW-1:0]       cap;
    logic [NW-1:0]       m;

    assign mag  = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign sh   = {r_rem, r_qd[NW-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle shifted in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qd   <= {mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[W-1];
            r_zero <= (i_num == '0);
        end else if (r_busy) begin
            r_qd  <= {r_qd[NW-2:0], ge};
            r_rem <= ge ? diff[PERIOD_W-1:0] : sh[PERIOD_W-1:0];
        end
    end

    always_comb begin
        cap = r_neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
        m   = (r_qd > cap) ? cap : r_qd;
        if (r_zero) begin
            o_q = '0;
        end else begin
            o_q = r_neg ? -m[W-1:0] : m[W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== src/pid_dpath.sv =====
module pid_dpath import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_ctl                      i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_sp,
    input  logic signed [DATA_WIDTH-1:0] i_fb,
    input  logic [PERIOD_W-1:0]          i_per,
    input  logic signed [DATA_WIDTH-1:0] i_gain_p,
    input  logic signed [DATA_WIDTH-1:0] i_gain_i,
    input  logic signed [DATA_WIDTH-1:0] i_gain_d,
    input  logic [LIMIT_W-1:0]           i_int_lim,
    input  logic [LIMIT_W-1:0]           i_der_lim,
    input  logic [LIMIT_W-1:0]           i_out_lim,
    input  logic                         i_out_stall,
    output t_dp_stat                     o_stat,
    output logic                         o_out_valid,
    output t_out_item                    o_out_data
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = ((W > 32) ? W : 32) + 1;

    localparam logic signed [W+1:0] A_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] A_MIN = ~A_MAX;

    logic signed [W-1:0]   r_sp;
    logic signed [W-1:0]   r_fb;
    logic [PERIOD_W-1:0]   r_per;
    logic signed [W-1:0]   r_err;
    logic signed [W-1:0]   r_lerr;
    logic signed [W-1:0]   r_lder;
    logic signed [W-1:0]   r_integ;
    logic signed [W-1:0]   r_prop;
    logic signed [W-1:0]   r_der;
    logic signed [W-1:0]   r_tmp;
    logic signed [W-1:0]   r_sum;
    logic signed [W+1:0]   r_acc;
    logic signed [IO_W-1:0] r_drive;
    logic                  r_hit;
    logic                  r_o_valid;

    logic signed [CW-1:0]  a_ext;
    logic signed [CW-1:0]  b_ext;
    logic signed [W-1:0]   a_w;
    logic signed [W-1:0]   b_w;
    logic signed [W+1:0]   a_x;
    logic signed [W+1:0]   b_x;
    logic [W:0]            cl;
    logic signed [W-1:0]   alu_res;
    logic signed [W-1:0]   wr_val;
    logic                  wr_en;
    logic                  mul_start;
    logic                  div_start;
    logic                  mul_done;
    logic                  div_done;
    logic signed [W-1:0]   mul_p;
    logic signed [W-1:0]   div_q;
    logic                  out_free;
    logic                  out_fire;
    logic signed [CW-1:0]  drive_ext;

    function automatic logic signed [CW-1:0] f_src(input t_src s);
        logic signed [CW-1:0] v;
        case (s)
            SRC_SP:    v = CW'(r_sp);
            SRC_FB:    v = CW'(r_fb);
            SRC_PER:   v = CW'(r_per);
            SRC_ERR:   v = CW'(r_err);
            SRC_LERR:  v = CW'(r_lerr);
            SRC_LDER:  v = CW'(r_lder);
            SRC_INTEG: v = CW'(r_integ);
            SRC_PROP:  v = CW'(r_prop);
            SRC_DER:   v = CW'(r_der);
            SRC_TMP:   v = CW'(r_tmp);
            SRC_SUM:   v = CW'(r_sum);
            SRC_GP:    v = CW'(i_gain_p);
            SRC_GI:    v = CW'(i_gain_i);
            SRC_GD:    v = CW'(i_gain_d);
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+1:0] x);
        logic signed [W-1:0] r;
        if (x > A_MAX) begin
            r = A_MAX[W-1:0];
        end else if (x < A_MIN) begin
            r = A_MIN[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    // returns {hit, clamped value}
    function automatic logic [W:0] f_clamp(input logic signed [W-1:0] x,
                                           input logic [LIMIT_W-1:0] lim);
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] le;
        logic signed [CW-1:0] ln;
        logic [W:0]           r;
        xe = CW'(x);
        le = CW'(lim);
        ln = -le;
        if (xe > le) begin
            r = {1'b1, le[W-1:0]};
        end else if (xe < ln) begin
            r = {1'b1, ln[W-1:0]};
        end else begin
            r = {1'b0, x};
        end
        return r;
    endfunction

    assign a_ext = f_src(i_ctl.uw.src_a);
    assign b_ext = f_src(i_ctl.uw.src_b);
    assign a_w   = a_ext[W-1:0];
    assign b_w   = b_ext[W-1:0];
    assign a_x   = (W+2)'(a_w);
    assign b_x   = (W+2)'(b_w);

    always_comb begin
        case (i_ctl.uw.op)
            OP_CLI:  cl = f_clamp(a_w, i_int_lim);
            OP_CLD:  cl = f_clamp(a_w, i_der_lim);
            OP_CLO:  cl = f_clamp(a_w, i_out_lim);
            default: cl = {1'b0, a_w};
        endcase
    end

    always_comb begin
        case (i_ctl.uw.op)
            OP_SUB:    alu_res = f_sat(a_x - b_x);
            OP_ADD:    alu_res = f_sat(a_x + b_x);
            OP_SATACC: alu_res = f_sat(r_acc);
            OP_CLI:    alu_res = cl[W-1:0];
            OP_CLD:    alu_res = cl[W-1:0];
            default:   alu_res = a_w;
        endcase
    end

    assign mul_start = i_ctl.fire && (i_ctl.uw.op == OP_MUL);
    assign div_start = i_ctl.fire && (i_ctl.uw.op == OP_DIV);
    assign wr_en     = (i_ctl.fire && !mul_start && !div_start) || mul_done || div_done;
    assign wr_val    = mul_done ? mul_p : (div_done ? div_q : alu_res);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign out_fire  = i_ctl.fire && (i_ctl.uw.op == OP_CLO);
    assign drive_ext = CW'($signed(cl[W-1:0]));

    pid_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a_ext),
        .i_b     (b_ext),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    pid_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (a_w),
        .i_den   (r_per),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // controller state carried from one transaction to the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_lerr  <= '0;
            r_lder  <= '0;
        end else if (wr_en) begin
            case (i_ctl.uw.dst)
                DST_INTEG: r_integ <= wr_val;
                DST_LERR:  r_lerr  <= wr_val;
                DST_LDER:  r_lder  <= wr_val;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sp  <= i_sp;
            r_fb  <= i_fb;
            r_per <= i_per;
        end
        if (wr_en) begin
            case (i_ctl.uw.dst)
                DST_ERR:  r_err  <= wr_val;
                DST_PROP: r_prop <= wr_val;
                DST_DER:  r_der  <= wr_val;
                DST_TMP:  r_tmp  <= wr_val;
                DST_SUM:  r_sum  <= wr_val;
                default:  ;
            endcase
        end
        if (i_ctl.fire && (i_ctl.uw.op == OP_ACCLD)) begin
            r_acc <= a_x;
        end else if (i_ctl.fire && (i_ctl.uw.op == OP_ACCADD)) begin
            r_acc <= r_acc + a_x;
        end
        if (out_fire) begin
            r_drive <= drive_ext[IO_W-1:0];
            r_hit   <= cl[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_stat.unit_done         = mul_done || div_done;
    assign o_stat.out_free          = out_free;
    assign o_out_valid              = r_o_valid;
    assign o_out_data.drive         = r_drive;
    assign o_out_data.drive_clamped = r_hit;

endmodule

// ===== src/pid_useq.sv =====
module pid_useq import pid_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_incremental,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_seq;
    t_uword            uw;
    logic              is_multi;
    logic              is_last;
    logic              take_jump;
    logic              in_accept;

    assign uw       = f_ucode(r_step);
    assign is_multi = (uw.op == OP_MUL) || (uw.op == OP_DIV);
    assign is_last  = (uw.op == OP_CLO);

    always_comb begin
        case (uw.cond)
            COND_ALWAYS: take_jump = 1'b1;
            COND_INC:    take_jump = i_incremental;
            COND_POS:    take_jump = !i_incremental;
            default:     take_jump = 1'b0;
        endcase
    end

    assign step_seq  = take_jump ? uw.target : (r_step + 1'b1);
    assign in_accept = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                    n_step  = '0;
                end
            end
            ST_EXEC: begin
                if (is_multi) begin
                    n_state = ST_WAIT;
                end else if (is_last) begin
                    if (i_stat.out_free) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end
                end else begin
                    n_step = step_seq;
                end
            end
            ST_WAIT: begin
                if (i_stat.unit_done) begin
                    n_state = ST_EXEC;
                    n_step  = step_seq;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        o_ctl.load = (r_state == ST_IDLE) && i_in_valid;
        o_ctl.uw   = uw;
        case (r_state)
            ST_EXEC: o_ctl.fire = is_last ? i_stat.out_free : 1'b1;
            default: o_ctl.fire = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTH
    a_wait_on_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ((uw.op == OP_MUL) || (uw.op == OP_DIV)))
        else $error("waiting on a step that starts no unit");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.unit_done |-> (r_state == ST_WAIT))
        else $error("unit finished while sequencer was not waiting");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_state == ST_EXEC) && (r_step == '0)))
        else $error("accepted transaction did not start the program");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEP_W'(N_STEPS))
        else $error("step counter left the program");
`endif

endmodule

// ===== src/pid_position_incremental.sv =====
// PID controller in position or incremental form, signed fixed point with FRAC_BITS
// fractional bits held at DATA_WIDTH bits. Each input transaction carries setpoint,
// feedback and sample period and yields one clamped drive value with a clamp flag.
// A short microcode program steps a shared datapath: one restoring divider that
// produces one quotient bit per cycle, and one multiplier that consumes one
// 16-bit slice of its second operand per cycle (four products per item). One item
// is worked at a time and the next is taken as soon as the result sits in the
// output register. Registers are to be written through the plain write port
// while the block is idle; the block itself does not enforce this.
module pid_position_incremental import pid_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = ((W > 32) ? W : 32) + 1;

    localparam logic signed [CW-1:0] C_DMAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] C_DMIN = ~C_DMAX;

    logic                r_incremental;
    logic signed [W-1:0] r_gain_p;
    logic signed [W-1:0] r_gain_i;
    logic signed [W-1:0] r_gain_d;
    logic [LIMIT_W-1:0]  r_int_lim;
    logic [LIMIT_W-1:0]  r_der_lim;
    logic [LIMIT_W-1:0]  r_out_lim;

    logic signed [W-1:0] sp_w;
    logic signed [W-1:0] fb_w;
    logic signed [W-1:0] cfg_gain;
    t_dp_ctl             ctl;
    t_dp_stat            stat;

    function automatic logic signed [W-1:0] f_sat_in(input logic signed [IO_W-1:0] v);
        logic signed [CW-1:0] x;
        logic signed [W-1:0]  r;
        x = CW'(v);
        if (x > C_DMAX) begin
            r = C_DMAX[W-1:0];
        end else if (x < C_DMIN) begin
            r = C_DMIN[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    assign sp_w     = f_sat_in(i_in_data.setpoint);
    assign fb_w     = f_sat_in(i_in_data.feedback);
    assign cfg_gain = f_sat_in(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incremental <= 1'b0;
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_int_lim     <= '1;
            r_der_lim     <= '1;
            r_out_lim     <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INCREMENTAL: r_incremental <= i_cfg_data[0];
                CFG_GAIN_P:      r_gain_p      <= cfg_gain;
                CFG_GAIN_I:      r_gain_i      <= cfg_gain;
                CFG_GAIN_D:      r_gain_d      <= cfg_gain;
                CFG_INT_LIMIT:   r_int_lim     <= i_cfg_data[LIMIT_W-1:0];
                CFG_DER_LIMIT:   r_der_lim     <= i_cfg_data[LIMIT_W-1:0];
                CFG_OUT_LIMIT:   r_out_lim     <= i_cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    pid_useq u_useq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_incremental (r_incremental),
        .i_stat        (stat),
        .o_ctl         (ctl)
    );

    pid_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sp        (sp_w),
        .i_fb        (fb_w),
        .i_per       (i_in_data.period),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_int_lim   (r_int_lim),
        .i_der_lim   (r_der_lim),
        .i_out_lim   (r_out_lim),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== dv/tb_pid_position_incremental.sv =====
`timescale 1ns / 100ps

module tb_pid_position_incremental;
    import pid_pkg::*;

    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int PHASES            = 3;
    localparam int SEGMENTS          = 3;
    localparam int ITEMS_PER_SEGMENT = 150;
    localparam int HOLD_OFF_CYCLES   = 600;
    localparam int TAIL_CYCLES       = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam longint Q_MAX = 64'sh0000_0000_7fff_ffff;
    localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] W_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN   = 32'h8000_0000;
    localparam logic [30:0] PER_MAX = 31'h7fff_ffff;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        t_in_item             item;
        bit                   typed;
        t_out_item            want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              in_data = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pid_position_incremental u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state and register copy
    bit     pm_inc = 1'b0;
    longint pm_gp = 0, pm_gi = 0, pm_gd = 0;
    longint pm_ilim = Q_MAX, pm_dlim = Q_MAX, pm_olim = Q_MAX;
    longint pm_integ = 0, pm_lerr = 0, pm_lder = 0;

    t_out_item drive_expected[$];
    t_row      plan[$];

    int unsigned n_cycles = 0;
    int unsigned n_err = 0;
    int unsigned n_in = 0, n_out = 0, n_pos = 0, n_inc = 0, n_clamp = 0, n_writes = 0;
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 63;
    int unsigned hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    initial begin
        wait (n_cycles >= CYCLE_LIMIT);
        $display("tb_pid_position_incremental: FAIL");
        $finish;
    end

    function automatic longint sat_q(longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    function automatic longint clamp_q(longint x, longint lim, output bit hit);
        hit = 1'b1;
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        hit = 1'b0;
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit          neg;
        logic [63:0] ma, mb, p, cap;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb) >> FRAC_BITS_DEF;
        cap = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (p > cap) p = cap;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint fx_div(longint a, longint den);
        bit          neg;
        logic [63:0] ma, q, cap;
        neg = a < 0;
        if (den == 0) return (a == 0) ? 0 : (neg ? Q_MIN : Q_MAX);
        ma  = neg ? -a : a;
        q   = (ma << FRAC_BITS_DEF) / 64'(den);
        cap = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > cap) q = cap;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void pid_load_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            CFG_INCREMENTAL: pm_inc = val[0];
            CFG_GAIN_P:      pm_gp = longint'($signed(val));
            CFG_GAIN_I:      pm_gi = longint'($signed(val));
            CFG_GAIN_D:      pm_gd = longint'($signed(val));
            CFG_INT_LIMIT:   pm_ilim = longint'(val[30:0]);
            CFG_DER_LIMIT:   pm_dlim = longint'(val[30:0]);
            CFG_OUT_LIMIT:   pm_olim = longint'(val[30:0]);
            default: ;
        endcase
    endfunction

    function automatic t_out_item pid_predict(t_in_item it);
        longint    sp, fb, per, e, prop, der, sum, drv;
        bit        hit;
        t_out_item r;
        sp  = longint'($signed(it.setpoint));
        fb  = longint'($signed(it.feedback));
        per = longint'(it.period);
        e   = sat_q(sp - fb);
        if (pm_inc) begin
            pm_integ = clamp_q(e, pm_ilim, hit);
            prop     = fx_div(sat_q(e - pm_lerr), per);
            pm_lerr  = e;
            der      = sat_q(prop - pm_lder);
            pm_lder  = der;
        end else begin
            prop     = e;
            der      = fx_div(sat_q(e - pm_lerr), per);
            pm_lerr  = e;
            pm_integ = clamp_q(sat_q(pm_integ + fx_mul(e, per)), pm_ilim, hit);
        end
        der = clamp_q(der, pm_dlim, hit);
        sum = sat_q(fx_mul(pm_gp, prop) + fx_mul(pm_gi, pm_integ) + fx_mul(pm_gd, der));
        if (pm_inc) sum = fx_mul(sum, per);
        drv = clamp_q(sum, pm_olim, hit);
        r.drive         = drv[31:0];
        r.drive_clamped = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_err++;
        $display("mismatch at cycle %0d: %s", n_cycles, msg);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item got;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (pm_inc) n_inc++;
        else n_pos++;
        got = pid_predict(it);
        drive_expected.push_back(typed ? want : got);
        n_in++;
        @(negedge i_clk);
    endtask

    task automatic drain_drive_results();
        in_valid = 1'b0;
        while (drive_expected.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        pid_load_reg(idx, val);
        n_writes++;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        t_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.val   = val;
        r.item  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_item(logic [31:0] sp, logic [31:0] fb, logic [30:0] per,
                                      bit typed = 1'b0, logic [31:0] drv = '0,
                                      bit clamped = 1'b0);
        t_row r;
        r.kind               = ROW_ITEM;
        r.idx                = '0;
        r.val                = '0;
        r.item.setpoint      = sp;
        r.item.feedback      = fb;
        r.item.period        = per;
        r.typed              = typed;
        r.want.drive         = drv;
        r.want.drive_clamped = clamped;
        plan.push_back(r);
    endfunction

    function automatic void build_directed_plan();
        // gains at reset are zero
        plan_item(32'h0, 32'h0, 31'd1, 1'b1, 32'h0, 1'b0);
        plan_item(W_MAX, W_MIN, PER_MAX, 1'b1, 32'h0, 1'b0);
        plan_item(W_MIN, W_MAX, 31'd0, 1'b1, 32'h0, 1'b0);
        plan_item(32'h0000_1234, 32'hffff_edcc, 31'h1_0000, 1'b1, 32'h0, 1'b0);
        plan_cfg(CFG_GAIN_P, Q_ONE);
        plan_item(32'h0005_0000, 32'h0002_0000, 31'h1_0000, 1'b1, 32'h0003_0000, 1'b0);
        plan_item(W_MAX, W_MIN, 31'd1, 1'b1, W_MAX, 1'b0);
        plan_cfg(CFG_OUT_LIMIT, 32'h0);
        plan_item(Q_ONE, 32'h0, 31'd1, 1'b1, 32'h0, 1'b1);
        plan_item(32'h0, 32'h0, 31'd1, 1'b1, 32'h0, 1'b0);
        plan_cfg(CFG_OUT_LIMIT, W_MAX);
        plan_cfg(CFG_GAIN_I, 32'hffff_0000);
        plan_cfg(CFG_GAIN_D, 32'h0000_8000);
        plan_cfg(CFG_INT_LIMIT, 32'h0002_0000);
        plan_cfg(CFG_DER_LIMIT, 32'h0);
        plan_item(32'h0003_0000, 32'h0, 31'h8000);
        plan_item(W_MIN, W_MAX, PER_MAX);
        plan_item(32'h0, Q_ONE, 31'd0);
        plan_item(32'h0, Q_ONE, 31'd0);
        plan_cfg(CFG_DER_LIMIT, W_MAX);
        plan_cfg(CFG_GAIN_D, W_MIN);
        plan_cfg(CFG_GAIN_P, W_MAX);
        plan_item(32'h0012_3456, 32'hff9a_bcdf, 31'h100);
        plan_item(32'hffff_fff0, 32'h0000_0010, PER_MAX);
        // write beyond the register list is ignored
        plan_cfg(CFG_UNUSED, 32'hffff_ffff);
        plan_cfg(CFG_GAIN_P, Q_ONE);
        plan_cfg(CFG_GAIN_I, 32'h0000_4000);
        plan_cfg(CFG_GAIN_D, 32'hfffe_0000);
        plan_cfg(CFG_INT_LIMIT, W_MAX);
        plan_cfg(CFG_INCREMENTAL, 32'h1);
        plan_item(Q_ONE, 32'h0, 31'h1_0000);
        plan_item(32'h0002_0000, 32'h0, 31'h1_0000);
        plan_item(W_MIN, W_MAX, 31'd1);
        plan_item(W_MAX, W_MIN, 31'd0);
        plan_item(32'h0, 32'h0, PER_MAX);
        plan_item(W_MAX, 32'h0, PER_MAX);
        plan_cfg(CFG_INT_LIMIT, 32'h0);
        plan_cfg(CFG_OUT_LIMIT, 32'h0004_0000);
        plan_item(32'h0005_0000, 32'h0001_0000, 31'h2_0000);
        plan_item(32'h0, 32'h0007_0000, 31'h0_4000);
        plan_cfg(CFG_INCREMENTAL, 32'h0);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return 32'h0;
            3, 4, 5: return $urandom_range(32'h001f_ffff) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(11))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return 32'h0;
            3:       return $urandom();
            default: return $urandom_range(32'h0007_ffff) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] pick_period();
        case ($urandom_range(19))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return PER_MAX;
            3, 4, 5: return 31'($urandom());
            default: return 31'($urandom_range(32'h0002_0000, 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(7))
            0:       return 32'h0;
            1, 2:    return W_MAX;
            3, 4:    return $urandom_range(32'h007f_ffff);
            default: return {1'b0, 31'($urandom())};
        endcase
    endfunction

    // receiver, with one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (drive_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction drive=%h clamped=%b",
                                          o_out_data.drive, o_out_data.drive_clamped));
            end else begin
                want = drive_expected.pop_front();
                if (o_out_data.drive !== want.drive)
                    report_mismatch($sformatf("drive %h, expected %h",
                                              o_out_data.drive, want.drive));
                if (o_out_data.drive_clamped !== want.drive_clamped)
                    report_mismatch($sformatf("drive_clamped %b, expected %b",
                                              o_out_data.drive_clamped, want.drive_clamped));
            end
            n_out++;
            if (o_out_data.drive_clamped) n_clamp++;
        end
    end

    initial begin
        t_in_item    it;
        logic [31:0] seg_sp, fb_walk;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        build_directed_plan();
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                drain_drive_results();
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                send_sample(plan[k].item, plan[k].typed, plan[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 15 : 0;
            for (int sg = 0; sg < SEGMENTS; sg++) begin
                drain_drive_results();
                write_reg(CFG_INCREMENTAL, 32'((ph * SEGMENTS + sg) % 2));
                write_reg(CFG_GAIN_P, pick_gain());
                write_reg(CFG_GAIN_I, pick_gain());
                write_reg(CFG_GAIN_D, pick_gain());
                write_reg(CFG_INT_LIMIT, pick_limit());
                write_reg(CFG_DER_LIMIT, pick_limit());
                write_reg(CFG_OUT_LIMIT, pick_limit());
                if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom());
                // long receiver hold-off so the block backs up into its input
                if (ph == 0 && sg == 0) hold_left = HOLD_OFF_CYCLES;
                seg_sp  = $urandom_range(32'h000f_ffff) - 32'h0008_0000;
                fb_walk = $urandom_range(32'h000f_ffff) - 32'h0008_0000;
                for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
                    if ($urandom_range(9) < 7) begin
                        fb_walk     = fb_walk + ($urandom_range(32'h0003_ffff) - 32'h0002_0000);
                        it.setpoint = seg_sp;
                        it.feedback = fb_walk;
                        it.period   = 31'($urandom_range(32'h0002_0000, 1));
                    end else begin
                        it.setpoint = pick_value();
                        it.feedback = pick_value();
                        it.period   = pick_period();
                    end
                    send_sample(it, 1'b0, '0);
                end
            end
        end

        drain_drive_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions in and %0d out: %0d position form, %0d incremental",
                 n_in, n_out, n_pos, n_inc);
        $display("%0d clamped outputs, %0d register writes, %0d cycles, %0d mismatches",
                 n_clamp, n_writes, n_cycles, n_err);
        if (n_err == 0) begin
            $display("tb_pid_position_incremental: PASS");
        end else begin
            $display("tb_pid_position_incremental: FAIL");
        end
        $finish;
    end

endmodule
